>>> src/multi_encoding_text_decoder_defines.svh
// Assertion helpers used by the decoder's top-level file.
`ifndef MULTI_ENCODING_TEXT_DECODER_DEFINES_SVH
`define MULTI_ENCODING_TEXT_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MED_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MED_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/med_pkg.sv
package med_pkg;

  typedef enum logic [1:0] {
    ENC_UTF8   = 2'd0,
    ENC_UTF16  = 2'd1,
    ENC_UTF32  = 2'd2,
    ENC_LATIN1 = 2'd3
  } enc_mode_t;

  localparam int UTF8_MAX_BYTES = 6;
  localparam int UTF8_HELD_DEPTH = UTF8_MAX_BYTES - 1;

  typedef logic [UTF8_MAX_BYTES-1:0][7:0] utf8_buf_t;

  localparam logic [15:0] SURR_MASK = 16'hFC00;
  localparam logic [15:0] HIGH_SURR = 16'hD800;
  localparam logic [15:0] LOW_SURR  = 16'hDC00;
  // (0xD800 << 10) - 0x10000 + 0xDC00
  localparam logic [31:0] SURR_OFFSET = 32'h035F_DC00;

  typedef struct packed {
    logic        emit;
    logic [31:0] cp;
    logic        last;
    logic        fin;
    logic        spill;
    logic [31:0] spill_cp;
    logic        spill_fin;
    logic        flush;
    utf8_buf_t   flush_buf;
    logic [2:0]  flush_n;
  } dec_out_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] cp;
    logic        last;
  } flush_out_t;

  function automatic logic [2:0] trailing_of(input logic [7:0] b);
    logic [2:0] t;
    if (b < 8'hC0)      t = 3'd0;
    else if (b < 8'hE0) t = 3'd1;
    else if (b < 8'hF0) t = 3'd2;
    else if (b < 8'hF8) t = 3'd3;
    else if (b < 8'hFC) t = 3'd4;
    else                t = 3'd5;
    return t;
  endfunction

  function automatic logic [31:0] utf8_offset(input logic [2:0] t);
    logic [31:0] off;
    case (t)
      3'd1:    off = 32'h0000_3080;
      3'd2:    off = 32'h000E_2080;
      3'd3:    off = 32'h03C8_2080;
      3'd4:    off = 32'hFA08_2080;
      3'd5:    off = 32'h8208_2080;
      default: off = 32'h0000_0000;
    endcase
    return off;
  endfunction

  // Bytes 0..t of w, six bits apart, minus the offset for that length.
  function automatic logic [31:0] utf8_value(input utf8_buf_t w, input logic [2:0] t);
    logic [31:0] acc;
    acc = '0;
    for (int k = 0; k < UTF8_MAX_BYTES; k++) begin
      if (3'(k) <= t) begin
        acc = acc + ({24'b0, w[k]} << (6 * (t - 3'(k))));
      end
    end
    return acc - utf8_offset(t);
  endfunction

endpackage

>>> src/med_in_if.sv
interface med_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_unit;
  logic        text_end;

  modport source (output valid, output code_unit, output text_end, input ready);
  modport sink   (input valid, input code_unit, input text_end, output ready);
endinterface

>>> src/med_out_if.sv
interface med_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] codepoint;
  logic        run_last;
  logic        final_codepoint;

  modport source (output valid, output codepoint, output run_last, output final_codepoint,
                  input ready);
  modport sink   (input valid, input codepoint, input run_last, input final_codepoint,
                  output ready);
endinterface

>>> src/multi_encoding_text_decoder.sv
// Decodes a stream of code units into codepoints under the encoding held in
// the configuration register (UTF-8, UTF-16, UTF-32 or Latin-1); a write to
// that register also drops any partial sequence. One code unit is accepted
// per cycle while the output register is free, and its codepoint appears in
// the output register in the next cycle. Two cases take longer: a UTF-16 unit
// that releases an unpaired high surrogate and itself produces two codepoints,
// so the second waits in a spill register and input is held meanwhile; and a
// UTF-8 unit that ends the text, whose held bytes are loaded into the flush
// unit and then walked one codepoint per cycle while the output is free, 1 to
// 6 codepoints, input held until the last one is in the output register.
`include "multi_encoding_text_decoder_defines.svh"

module multi_encoding_text_decoder import med_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  med_in_if.sink     in_ch,
  med_out_if.source  out_ch
);

  enc_mode_t   mode_r;
  dec_out_t    dec;
  flush_out_t  fl;
  logic        fl_busy;
  logic        slot_free;
  logic        in_acc;
  logic        fl_take;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_cp_r, out_cp_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_fin_r, out_fin_nxt;
  logic        spill_v_r, spill_v_nxt;
  logic [31:0] spill_cp_r, spill_cp_nxt;
  logic        spill_fin_r, spill_fin_nxt;

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = slot_free && !spill_v_r && !fl_busy;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign fl_take     = slot_free && !spill_v_r;

  med_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (cfg_we),
    .accept   (in_acc),
    .mode     (mode_r),
    .unit     (in_ch.code_unit),
    .text_end (in_ch.text_end),
    .res      (dec)
  );

  med_flush u_flush (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc && dec.flush),
    .start_buf (dec.flush_buf),
    .start_n   (dec.flush_n),
    .take      (fl_take),
    .fo        (fl),
    .busy      (fl_busy)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_cp_nxt    = out_cp_r;
    out_last_nxt  = out_last_r;
    out_fin_nxt   = out_fin_r;
    spill_v_nxt   = spill_v_r;
    spill_cp_nxt  = spill_cp_r;
    spill_fin_nxt = spill_fin_r;
    if (slot_free) begin
      if (spill_v_r) begin
        out_valid_nxt = 1'b1;
        out_cp_nxt    = spill_cp_r;
        out_last_nxt  = 1'b1;
        out_fin_nxt   = spill_fin_r;
        spill_v_nxt   = 1'b0;
      end else if (fl.valid) begin
        out_valid_nxt = 1'b1;
        out_cp_nxt    = fl.cp;
        out_last_nxt  = fl.last;
        out_fin_nxt   = fl.last;
      end else if (in_acc && dec.emit) begin
        out_valid_nxt = 1'b1;
        out_cp_nxt    = dec.cp;
        out_last_nxt  = dec.last;
        out_fin_nxt   = dec.fin;
        spill_v_nxt   = dec.spill;
        spill_cp_nxt  = dec.spill_cp;
        spill_fin_nxt = dec.spill_fin;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ENC_UTF8;
      out_valid_r <= 1'b0;
      spill_v_r   <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= enc_mode_t'(cfg_wdata);
      out_valid_r <= out_valid_nxt;
      spill_v_r   <= spill_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cp_r    <= out_cp_nxt;
    out_last_r  <= out_last_nxt;
    out_fin_r   <= out_fin_nxt;
    spill_cp_r  <= spill_cp_nxt;
    spill_fin_r <= spill_fin_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.codepoint       = out_cp_r;
  assign out_ch.run_last        = out_last_r;
  assign out_ch.final_codepoint = out_fin_r;

  `MED_ASSERT_IMP(a_spill_behind_out, clk, rst_n, spill_v_r, out_valid_r, "spill without output")
  `MED_ASSERT_IMP(a_spill_no_flush, clk, rst_n, spill_v_r, !fl_busy, "spill during flush")
  `MED_ASSERT_NXT(a_spill_load, clk, rst_n, in_acc && dec.spill, spill_v_r && out_valid_r,
                  "two-result item not loaded")
  `MED_ASSERT_NXT(a_flush_load, clk, rst_n, in_acc && dec.flush, fl_busy && !out_valid_r,
                  "flush not started")
  `MED_ASSERT_IMP(a_final_is_last, clk, rst_n, out_valid_r && out_fin_r, out_last_r,
                  "final codepoint not last of its item")

endmodule

>>> src/med_decode.sv
module med_decode import med_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clear,
  input  logic        accept,
  input  enc_mode_t   mode,
  input  logic [31:0] unit,
  input  logic        text_end,
  output dec_out_t    res
);

  logic [7:0]  held_r [UTF8_HELD_DEPTH];
  logic [2:0]  hc_r, hc_nxt;
  logic [2:0]  need_r, need_nxt;
  logic [15:0] hs_r, hs_nxt;
  logic        sp_r, sp_nxt;
  logic        store_byte;

  logic [7:0]  b;
  logic [15:0] u;
  utf8_buf_t   buf_w;
  logic [2:0]  t0;
  logic        is_low, is_high;

  always_comb begin
    b = unit[7:0];
    u = unit[15:0];
    for (int k = 0; k < UTF8_HELD_DEPTH; k++) begin
      buf_w[k] = (3'(k) < hc_r) ? held_r[k] : b;
    end
    buf_w[UTF8_MAX_BYTES-1] = b;
    t0 = (hc_r == 3'd0) ? trailing_of(b) : need_r;
    is_low  = (u & SURR_MASK) == LOW_SURR;
    is_high = (u & SURR_MASK) == HIGH_SURR;
  end

  always_comb begin
    res        = '0;
    hc_nxt     = hc_r;
    need_nxt   = need_r;
    hs_nxt     = hs_r;
    sp_nxt     = sp_r;
    store_byte = 1'b0;
    case (mode)
      ENC_UTF8: begin
        if (text_end) begin
          res.flush     = 1'b1;
          res.flush_buf = buf_w;
          res.flush_n   = hc_r + 3'd1;
          hc_nxt        = '0;
          need_nxt      = '0;
        end else if (hc_r >= t0) begin
          res.emit = 1'b1;
          res.cp   = utf8_value(buf_w, t0);
          res.last = 1'b1;
          hc_nxt   = '0;
          need_nxt = '0;
        end else begin
          store_byte = 1'b1;
          hc_nxt     = hc_r + 3'd1;
          need_nxt   = t0;
        end
      end
      ENC_UTF16: begin
        if (sp_r && is_low) begin
          res.emit = 1'b1;
          res.cp   = {6'b0, hs_r, 10'b0} + {16'b0, u} - SURR_OFFSET;
          res.last = 1'b1;
          res.fin  = text_end;
          sp_nxt   = 1'b0;
          hs_nxt   = '0;
        end else begin
          if (sp_r) begin
            res.emit = 1'b1;
            res.cp   = {16'b0, hs_r};
            sp_nxt   = 1'b0;
            hs_nxt   = '0;
          end
          if (is_high && !text_end) begin
            // Hold the high surrogate until its partner shows up.
            sp_nxt   = 1'b1;
            hs_nxt   = u;
            res.last = res.emit;
          end else if (sp_r) begin
            res.spill     = 1'b1;
            res.spill_cp  = {16'b0, u};
            res.spill_fin = text_end;
          end else begin
            res.emit = 1'b1;
            res.cp   = {16'b0, u};
            res.last = 1'b1;
            res.fin  = text_end;
          end
        end
      end
      ENC_UTF32: begin
        res.emit = 1'b1;
        res.cp   = unit;
        res.last = 1'b1;
        res.fin  = text_end;
      end
      default: begin
        res.emit = 1'b1;
        res.cp   = {24'b0, b};
        res.last = 1'b1;
        res.fin  = text_end;
      end
    endcase
    if (text_end) begin
      hc_nxt   = '0;
      need_nxt = '0;
      hs_nxt   = '0;
      sp_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      hc_r   <= '0;
      need_r <= '0;
      hs_r   <= '0;
      sp_r   <= 1'b0;
    end else if (accept) begin
      hc_r   <= hc_nxt;
      need_r <= need_nxt;
      hs_r   <= hs_nxt;
      sp_r   <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_byte) begin
      held_r[hc_r] <= b;
    end
  end

endmodule

>>> src/med_flush.sv
module med_flush import med_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  utf8_buf_t  start_buf,
  input  logic [2:0] start_n,
  input  logic       take,
  output flush_out_t fo,
  output logic       busy
);

  logic       act_r, act_nxt;
  utf8_buf_t  buf_r, buf_nxt;
  logic [2:0] n_r, n_nxt;
  logic [2:0] t;
  logic [2:0] used;

  always_comb begin
    t = trailing_of(buf_r[0]);
    // A lead whose sequence runs past the end goes out alone.
    if (t >= n_r) t = 3'd0;
    used     = t + 3'd1;
    fo.valid = act_r;
    fo.cp    = utf8_value(buf_r, t);
    fo.last  = (used == n_r);
    busy     = act_r;

    act_nxt = act_r;
    buf_nxt = buf_r;
    n_nxt   = n_r;
    if (start) begin
      act_nxt = 1'b1;
      buf_nxt = start_buf;
      n_nxt   = start_n;
    end else if (act_r && take) begin
      buf_nxt = buf_r >> (8 * used);
      n_nxt   = n_r - used;
      if (fo.last) act_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      n_r   <= '0;
    end else begin
      act_r <= act_nxt;
      n_r   <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

>>> sim/multi_encoding_text_decoder_tb.sv
module multi_encoding_text_decoder_tb;
  import med_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLD_CYCLES    = 90;
  localparam int PHASE_COUNT    = 10;
  localparam int PHASE_UNITS    = 48;

  localparam logic [31:0] SEQ_BIAS [6] = '{
    32'h0000_0000, 32'h0000_3080, 32'h000E_2080,
    32'h03C8_2080, 32'hFA08_2080, 32'h8208_2080
  };

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_UNIT,
    ROW_CHECKED
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] unit;
    logic        fin;
    logic [31:0] cp;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] cp;
    logic        run_last;
    logic        final_cp;
  } cp_rec_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  med_in_if  in_ch ();
  med_out_if out_ch ();

  multi_encoding_text_decoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the decoder state.
  enc_mode_t   enc_shadow = ENC_UTF8;
  logic [7:0]  held_b [5];
  int          held_n = 0;
  logic [15:0] hi_unit = '0;
  bit          hi_pending = 1'b0;

  cp_rec_t   unit_cps [$];
  cp_rec_t   pending_cps [$];
  stim_row_t offered_units [$];

  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  stim_row_t directed_rows [$] = '{
    '{ROW_CHECKED, 32'hFFFF_FF7F, 1'b0, 32'h0000_007F},
    '{ROW_UNIT,    32'h0000_00C3, 1'b0, 32'h0},
    '{ROW_UNIT,    32'h0000_00A9, 1'b0, 32'h0},
    '{ROW_UNIT,    32'h0000_00FD, 1'b0, 32'h0},
    '{ROW_UNIT,    32'h0000_00BF, 1'b0, 32'h0},
    '{ROW_UNIT,    32'h0000_00BF, 1'b0, 32'h0},
    '{ROW_UNIT,    32'h0000_00BF, 1'b0, 32'h0},
    '{ROW_UNIT,    32'h0000_00BF, 1'b0, 32'h0},
    '{ROW_UNIT,    32'h0000_00BF, 1'b1, 32'h0},
    '{ROW_CHECKED, 32'h0000_0080, 1'b0, 32'h0000_0080},
    '{ROW_UNIT,    32'h0000_00F0, 1'b0, 32'h0},
    '{ROW_UNIT,    32'h0000_009F, 1'b0, 32'h0},
    '{ROW_UNIT,    32'h0000_0098, 1'b1, 32'h0},
    '{ROW_CHECKED, 32'h0000_00FC, 1'b1, 32'h0000_00FC},
    '{ROW_CFG,     {30'd0, ENC_UTF16}, 1'b0, 32'h0},
    '{ROW_CHECKED, 32'hFFFF_0041, 1'b0, 32'h0000_0041},
    '{ROW_UNIT,    32'h0000_D83D, 1'b0, 32'h0},
    '{ROW_UNIT,    32'h0000_DE00, 1'b0, 32'h0},
    '{ROW_UNIT,    32'h0000_D800, 1'b0, 32'h0},
    '{ROW_UNIT,    32'h0000_0041, 1'b0, 32'h0},
    '{ROW_CHECKED, 32'h0000_DBFF, 1'b1, 32'h0000_DBFF},
    '{ROW_UNIT,    32'h0000_D800, 1'b0, 32'h0},
    '{ROW_CFG,     {30'd0, ENC_UTF16}, 1'b0, 32'h0},
    '{ROW_CHECKED, 32'h0000_DC00, 1'b1, 32'h0000_DC00},
    '{ROW_CFG,     {30'd0, ENC_UTF32}, 1'b0, 32'h0},
    '{ROW_CHECKED, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF},
    '{ROW_CHECKED, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_CFG,     {30'd0, ENC_LATIN1}, 1'b0, 32'h0},
    '{ROW_CHECKED, 32'hFFFF_FFFF, 1'b1, 32'h0000_00FF}
  };

  function automatic int lead_tail(input logic [7:0] b);
    if (b[7:6] != 2'b11) return 0;
    if (!b[5]) return 1;
    if (!b[4]) return 2;
    if (!b[3]) return 3;
    if (!b[2]) return 4;
    return 5;
  endfunction

  function automatic logic [31:0] join_bytes(input logic [7:0] seq [6], input int first,
                                             input int tail);
    logic [31:0] acc;
    acc = '0;
    for (int k = 0; k <= tail; k++) begin
      acc = (acc << 6) + {24'd0, seq[first + k]};
    end
    return acc - SEQ_BIAS[tail];
  endfunction

  function automatic void emit_cp(input logic [31:0] cp);
    unit_cps.push_back({cp, 1'b0, 1'b0});
  endfunction

  function automatic void clear_state();
    held_n = 0;
    hi_unit = '0;
    hi_pending = 1'b0;
  endfunction

  // Computes the codepoints that one accepted item releases into unit_cps.
  task automatic decode_unit(input logic [31:0] unit, input logic fin);
    logic [7:0]  seq [6];
    logic [15:0] u16;
    int          n;
    int          pos;
    int          tail;
    unit_cps.delete();
    case (enc_shadow)
      ENC_UTF8: begin
        for (int i = 0; i < held_n; i++) seq[i] = held_b[i];
        seq[held_n] = unit[7:0];
        n = held_n + 1;
        if (fin) begin
          // The text ran out: walk the bytes again, and a lead whose sequence
          // no longer fits goes out on its own.
          pos = 0;
          while (pos < n) begin
            tail = lead_tail(seq[pos]);
            if (pos + tail >= n) tail = 0;
            emit_cp(join_bytes(seq, pos, tail));
            pos += tail + 1;
          end
        end else begin
          tail = lead_tail(seq[0]);
          if (n > tail) begin
            emit_cp(join_bytes(seq, 0, tail));
            held_n = 0;
          end else begin
            for (int i = 0; i < n; i++) held_b[i] = seq[i];
            held_n = n;
          end
        end
      end
      ENC_UTF16: begin
        u16 = unit[15:0];
        if (hi_pending && ((u16 & SURR_MASK) == LOW_SURR)) begin
          emit_cp((({16'd0, hi_unit} - 32'h0000_D800) << 10)
                  + ({16'd0, u16} - 32'h0000_DC00) + 32'h0001_0000);
          hi_pending = 1'b0;
          hi_unit = '0;
        end else begin
          if (hi_pending) begin
            emit_cp({16'd0, hi_unit});
            hi_pending = 1'b0;
            hi_unit = '0;
          end
          if (((u16 & SURR_MASK) == HIGH_SURR) && !fin) begin
            hi_unit = u16;
            hi_pending = 1'b1;
          end else begin
            emit_cp({16'd0, u16});
          end
        end
      end
      ENC_UTF32:  emit_cp(unit);
      default:    emit_cp({24'd0, unit[7:0]});
    endcase
    if (unit_cps.size() > 0) begin
      unit_cps[unit_cps.size() - 1].run_last = 1'b1;
      unit_cps[unit_cps.size() - 1].final_cp = fin;
    end
    if (fin) clear_state();
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : scoreboard
    cp_rec_t   want;
    stim_row_t row;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_cps.size() == 0) begin
          report_mismatch("unexpected codepoint", out_ch.codepoint, '0);
        end else begin
          want = pending_cps.pop_front();
          if (out_ch.codepoint !== want.cp)
            report_mismatch("codepoint", out_ch.codepoint, want.cp);
          if (out_ch.run_last !== want.run_last)
            report_mismatch("run_last", {31'd0, out_ch.run_last}, {31'd0, want.run_last});
          if (out_ch.final_codepoint !== want.final_cp)
            report_mismatch("final_codepoint", {31'd0, out_ch.final_codepoint},
                            {31'd0, want.final_cp});
        end
      end
      if (cfg_we) begin
        enc_shadow = enc_mode_t'(cfg_wdata);
        clear_state();
      end
      if (in_ch.valid && in_ch.ready) begin
        row = offered_units.pop_front();
        decode_unit(in_ch.code_unit, in_ch.text_end);
        if (row.kind == ROW_CHECKED) begin
          pending_cps.push_back({row.cp, 1'b1, in_ch.text_end});
        end else begin
          foreach (unit_cps[i]) pending_cps.push_back(unit_cps[i]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: a random stall before each item, or a long hold-off on request.
  initial begin : result_side
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = hold_req ? HOLD_CYCLES : (no_idle ? 0 : $urandom_range(13, 0));
      hold_req = 1'b0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_unit(input stim_row_t row);
    int gap;
    gap = no_idle ? 0 : $urandom_range(13, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.code_unit <= row.unit;
    in_ch.text_end  <= row.fin;
    offered_units.push_back(row);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Waits until the decoder is idle, then writes the encoding.
  task automatic set_mode(input enc_mode_t mode);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cps.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic void add_unit(ref stim_row_t rows [$], input logic [31:0] unit,
                                   input int end_odds);
    rows.push_back('{ROW_UNIT, unit, ($urandom_range(end_odds - 1, 0) == 0), 32'h0});
  endfunction

  function automatic void add_utf8_seq(ref stim_row_t rows [$]);
    int         len;
    logic [7:0] lead;
    len = $urandom_range(6, 1);
    case (len)
      1: lead = 8'($urandom_range(8'h7F, 8'h00));
      2: lead = 8'($urandom_range(8'hDF, 8'hC0));
      3: lead = 8'($urandom_range(8'hEF, 8'hE0));
      4: lead = 8'($urandom_range(8'hF7, 8'hF0));
      5: lead = 8'($urandom_range(8'hFB, 8'hF8));
      default: lead = 8'($urandom_range(8'hFF, 8'hFC));
    endcase
    // Now and then a raw byte that may break the sequence around it.
    if ($urandom_range(6, 0) == 0) begin
      lead = 8'($urandom);
      len = 1;
    end
    add_unit(rows, {24'($urandom), lead}, 16);
    for (int i = 1; i < len; i++)
      add_unit(rows, {24'($urandom), 2'b10, 6'($urandom)}, 16);
  endfunction

  function automatic void add_utf16_group(ref stim_row_t rows [$]);
    case ($urandom_range(9, 0))
      0, 1, 2, 3: add_unit(rows, $urandom, 12);
      4, 5, 6: begin
        add_unit(rows, {16'($urandom), 6'b110110, 10'($urandom)}, 12);
        add_unit(rows, {16'($urandom), 6'b110111, 10'($urandom)}, 12);
      end
      7: add_unit(rows, {16'($urandom), 6'b110110, 10'($urandom)}, 12);
      8: add_unit(rows, {16'($urandom), 6'b110111, 10'($urandom)}, 12);
      default: begin
        add_unit(rows, {16'($urandom), 6'b110110, 10'($urandom)}, 12);
        add_unit(rows, {16'($urandom), 6'b110110, 10'($urandom)}, 12);
      end
    endcase
  endfunction

  initial begin : stimulus
    stim_row_t rows [$];
    enc_mode_t mode;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.code_unit = '0;
    in_ch.text_end  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) set_mode(enc_mode_t'(directed_rows[i].unit[1:0]));
      else send_unit(directed_rows[i]);
    end

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      mode = (ph < 4) ? enc_mode_t'(ph) : enc_mode_t'($urandom_range(3, 0));
      set_mode(mode);
      // Two phases hold the result side off while items keep coming.
      hold_req = (ph == 2 || ph == 7);
      no_idle = hold_req || ($urandom_range(3, 0) == 0);
      rows.delete();
      while (rows.size() < PHASE_UNITS) begin
        case (mode)
          ENC_UTF8:  add_utf8_seq(rows);
          ENC_UTF16: add_utf16_group(rows);
          ENC_UTF32: begin
            case ($urandom_range(7, 0))
              0:       add_unit(rows, 32'h0000_0000, 10);
              1:       add_unit(rows, 32'hFFFF_FFFF, 10);
              default: add_unit(rows, $urandom, 10);
            endcase
          end
          default:   add_unit(rows, $urandom, 10);
        endcase
      end
      foreach (rows[i]) send_unit(rows[i]);
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cps.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
